// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes, codes and types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int EXT_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPDATE_DRAIN,
        ST_RESULT
    } t_state;

    // outcome of the lookup pass, fixed in the decide step
    typedef struct packed {
        logic              upd;
        logic [IDX_W-1:0]  tgt;
        logic [CNT_W-1:0]  thr;
        logic              wr_key;
        logic              wr_data;
        logic              set_valid;
        logic              inc_count;
        logic              hit;
        logic [DATA_W-1:0] rv;
        logic              ev;
        logic [DATA_W-1:0] evk;
    } t_decision;

    // control strobes from the sequencer
    typedef struct packed {
        logic in_ready;
        logic issue;
        logic scan_phase;
        logic upd_phase;
        logic decide;
        logic load_out;
    } t_ctrl;

endpackage

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One word is taken at a time. A lookup pass walks the ENTRIES slots through
// one key comparator, one slot per cycle out of the key, data and rank
// memories; a second pass rewrites the ranks one slot per cycle. A get or put
// that touches an entry runs both passes before the next word is accepted; a
// get miss skips the rank pass. The sequential sweep of the rank memory sets
// this turnaround. The result sits in an output register, so the next word is
// taken while it waits.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    output logic                          o_evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_evicted_key
);

    localparam logic [lkvc_pkg::IDX_W-1:0] LAST_IDX = lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1);

    lkvc_pkg::t_state r_state, n_state;
    lkvc_pkg::t_ctrl  ctrl;
    lkvc_pkg::t_decision dec;

    logic [lkvc_pkg::CAP_W-1:0]  r_cap;
    logic [lkvc_pkg::CNT_W-1:0]  r_count;
    logic [lkvc_pkg::ENTRIES-1:0] r_valid;

    logic [lkvc_pkg::DATA_W-1:0] mem_key  [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] mem_data [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::IDX_W-1:0]  mem_rank [lkvc_pkg::ENTRIES];

    // latched word
    logic                        r_op;
    logic [lkvc_pkg::DATA_W-1:0] r_key;
    logic [lkvc_pkg::DATA_W-1:0] r_value;

    // read pipeline
    logic [lkvc_pkg::IDX_W-1:0]  r_addr;
    logic                        r_pvld;
    logic [lkvc_pkg::IDX_W-1:0]  r_pidx;
    logic [lkvc_pkg::DATA_W-1:0] r_rd_key;
    logic [lkvc_pkg::DATA_W-1:0] r_rd_data;
    logic [lkvc_pkg::IDX_W-1:0]  r_rd_rank;

    // lookup pass results
    logic                        r_hit;
    logic [lkvc_pkg::IDX_W-1:0]  r_hit_idx;
    logic [lkvc_pkg::IDX_W-1:0]  r_hit_rank;
    logic [lkvc_pkg::DATA_W-1:0] r_hit_data;
    logic                        r_lru_found;
    logic [lkvc_pkg::IDX_W-1:0]  r_lru_idx;
    logic [lkvc_pkg::IDX_W-1:0]  r_lru_rank;
    logic [lkvc_pkg::DATA_W-1:0] r_lru_key;
    logic                        r_free_found;
    logic [lkvc_pkg::IDX_W-1:0]  r_free_idx;

    lkvc_pkg::t_decision r_dec;

    logic                        r_out_valid;
    logic                        r_o_hit;
    logic [lkvc_pkg::DATA_W-1:0] r_o_rv;
    logic                        r_o_ev;
    logic [lkvc_pkg::DATA_W-1:0] r_o_evk;

    logic [lkvc_pkg::EXT_W-1:0]  cap_x;
    logic [lkvc_pkg::EXT_W-1:0]  eff_cap;
    logic                        need_evict;
    logic                        p_valid;
    logic                        key_eq;
    logic                        in_acc;

    assign in_acc  = i_in_valid && ctrl.in_ready;
    assign p_valid = r_valid[r_pidx];
    assign key_eq  = (r_rd_key == r_key);

    // capacity zero acts as one, anything above ENTRIES saturates
    always_comb begin
        cap_x = lkvc_pkg::EXT_W'(r_cap);
        if (cap_x == '0) begin
            eff_cap = lkvc_pkg::EXT_W'(1);
        end else if (cap_x > lkvc_pkg::EXT_W'(lkvc_pkg::ENTRIES)) begin
            eff_cap = lkvc_pkg::EXT_W'(lkvc_pkg::ENTRIES);
        end else begin
            eff_cap = cap_x;
        end
        need_evict = (lkvc_pkg::EXT_W'(r_count) >= eff_cap);
    end

    // decide: target slot and rank threshold for the rank pass
    always_comb begin
        dec           = '0;
        dec.tgt       = r_hit_idx;
        dec.thr       = lkvc_pkg::CNT_W'(r_hit_rank);
        if (r_hit) begin
            dec.upd     = 1'b1;
            dec.hit     = 1'b1;
            dec.wr_data = (r_op == lkvc_pkg::OP_PUT);
            dec.rv      = (r_op == lkvc_pkg::OP_GET) ? r_hit_data : '0;
        end else if (r_op == lkvc_pkg::OP_GET) begin
            dec.rv = lkvc_pkg::MISS_VALUE;
        end else if (need_evict) begin
            // evicted slot is reused; count stays
            dec.upd       = 1'b1;
            dec.tgt       = r_lru_idx;
            dec.thr       = lkvc_pkg::CNT_W'(r_lru_rank);
            dec.wr_key    = 1'b1;
            dec.wr_data   = 1'b1;
            dec.set_valid = 1'b1;
            dec.ev        = 1'b1;
            dec.evk       = r_lru_key;
        end else begin
            // every valid entry ages by one
            dec.upd       = 1'b1;
            dec.tgt       = r_free_idx;
            dec.thr       = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
            dec.wr_key    = 1'b1;
            dec.wr_data   = 1'b1;
            dec.set_valid = 1'b1;
            dec.inc_count = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = lkvc_pkg::ST_SCAN_DRAIN;
                end
            end
            lkvc_pkg::ST_SCAN_DRAIN: n_state = lkvc_pkg::ST_DECIDE;
            lkvc_pkg::ST_DECIDE: begin
                n_state = dec.upd ? lkvc_pkg::ST_UPDATE : lkvc_pkg::ST_RESULT;
            end
            lkvc_pkg::ST_UPDATE: begin
                if (r_addr == LAST_IDX) begin
                    n_state = lkvc_pkg::ST_UPDATE_DRAIN;
                end
            end
            lkvc_pkg::ST_UPDATE_DRAIN: n_state = lkvc_pkg::ST_RESULT;
            lkvc_pkg::ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = lkvc_pkg::ST_IDLE;
                end
            end
            default: n_state = lkvc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl = '0;
        unique case (r_state)
            lkvc_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
            lkvc_pkg::ST_SCAN: begin
                ctrl.issue      = 1'b1;
                ctrl.scan_phase = 1'b1;
            end
            lkvc_pkg::ST_SCAN_DRAIN: ctrl.scan_phase = 1'b1;
            lkvc_pkg::ST_DECIDE:     ctrl.decide     = 1'b1;
            lkvc_pkg::ST_UPDATE: begin
                ctrl.issue     = 1'b1;
                ctrl.upd_phase = 1'b1;
            end
            lkvc_pkg::ST_UPDATE_DRAIN: ctrl.upd_phase = 1'b1;
            lkvc_pkg::ST_RESULT: ctrl.load_out = !r_out_valid || i_out_ready;
            default: ctrl = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkvc_pkg::ST_IDLE;
            r_cap       <= lkvc_pkg::CAP_RESET;
            r_count     <= '0;
            r_valid     <= '0;
            r_pvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= ctrl.issue;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (ctrl.decide && dec.set_valid) begin
                r_valid[dec.tgt] <= 1'b1;
            end
            if (ctrl.decide && dec.inc_count) begin
                r_count <= r_count + lkvc_pkg::CNT_W'(1);
            end
            if (ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // address counter and latched word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (in_acc || ctrl.decide) begin
            r_addr <= '0;
        end else if (ctrl.issue) begin
            r_addr <= r_addr + lkvc_pkg::IDX_W'(1);
        end
        r_pidx <= r_addr;
        if (ctrl.decide) begin
            r_dec <= dec;
        end
    end

    // memories: one read and one write per cycle each
    always_ff @(posedge i_clk) begin
        r_rd_key  <= mem_key[r_addr];
        r_rd_data <= mem_data[r_addr];
        r_rd_rank <= mem_rank[r_addr];
        if (ctrl.decide && dec.wr_key) begin
            mem_key[dec.tgt] <= r_key;
        end
        if (ctrl.decide && dec.wr_data) begin
            mem_data[dec.tgt] <= r_value;
        end
        if (ctrl.upd_phase && r_pvld) begin
            if (r_pidx == r_dec.tgt) begin
                mem_rank[r_pidx] <= '0;
            end else if (p_valid &&
                         (lkvc_pkg::CNT_W'(r_rd_rank) < r_dec.thr)) begin
                mem_rank[r_pidx] <= r_rd_rank + lkvc_pkg::IDX_W'(1);
            end
        end
    end

    // lookup pass: key match, oldest valid entry, first free slot
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hit        <= 1'b0;
            r_lru_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (ctrl.scan_phase && r_pvld) begin
            if (p_valid && key_eq) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pidx;
                r_hit_rank <= r_rd_rank;
                r_hit_data <= r_rd_data;
            end
            if (p_valid && (!r_lru_found || (r_rd_rank > r_lru_rank))) begin
                r_lru_found <= 1'b1;
                r_lru_idx   <= r_pidx;
                r_lru_rank  <= r_rd_rank;
                r_lru_key   <= r_rd_key;
            end
            if (!p_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pidx;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (ctrl.load_out) begin
            r_o_hit <= r_dec.hit;
            r_o_rv  <= r_dec.rv;
            r_o_ev  <= r_dec.ev;
            r_o_evk <= r_dec.evk;
        end
    end

    // a get miss never reaches the rank pass, so its word comes from dec
    // captured in the decide step like every other word
    assign o_in_ready    = ctrl.in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rv;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_evk;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
        else $error("valid count above entry count");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lkvc_pkg::ST_IDLE) |-> ($countones(r_valid) == 32'(r_count)))
        else $error("valid count out of step with valid bits");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.decide && dec.inc_count) |-> r_free_found)
        else $error("insert without a free slot");

    a_evict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.decide && dec.ev) |-> r_lru_found)
        else $error("eviction without a valid entry");

endmodule
